### rtl/assert_macros.svh
// Assertion macros shared by the modular exponentiation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MEXP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define MEXP_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### rtl/mexp_pkg.sv
// Shared constants, types and control structures of the modular exponentiation core.
package mexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_SQUARE,
    OP_MULT
  } op_t;

  typedef enum logic [1:0] {
    RES_ACC,
    RES_ONE,
    RES_ZERO
  } res_t;

  typedef struct packed {
    logic load;
    logic start;
    op_t  op;
    logic step;
    logic wb_base;
    logic wb_acc;
    logic shift_exp;
    logic out_load;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_msb;
  } status_t;

endpackage

### rtl/mexp_if.sv
// Valid/ready channel interfaces for operands and results.
interface mexp_in_if;
  import mexp_pkg::*;

  logic  valid;
  logic  ready;
  word_t base;
  word_t exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;

  logic  valid;
  logic  ready;
  word_t power_mod;
  logic  modulus_zero;

  modport source (output valid, output power_mod, output modulus_zero, input ready);
  modport sink (input valid, input power_mod, input modulus_zero, output ready);
endinterface

### rtl/mexp_datapath.sv
// Datapath: modulus register, operand registers and a bit-serial modular multiplier.
module mexp_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  mexp_pkg::word_t  cfg_data,
  input  mexp_pkg::word_t  base,
  input  mexp_pkg::word_t  exponent,
  input  mexp_pkg::cmd_t   cmd,
  output mexp_pkg::status_t status,
  output mexp_pkg::word_t  power_mod,
  output logic             modulus_zero
);
  import mexp_pkg::*;

  word_t modulus;
  word_t base_q;
  word_t exp_q;
  word_t acc;
  word_t base_r;
  word_t a_op;
  word_t mult;
  word_t prod;
  word_t one_r;
  word_t step_val;

  logic [WIDTH+2:0] sum;
  logic [WIDTH+2:0] diff1;
  logic [WIDTH+2:0] diff2;

  assign one_r = (modulus == word_t'(1)) ? '0 : word_t'(1);

  assign status.mod_zero = (modulus == '0);
  assign status.exp_zero = (exp_q == '0);
  assign status.exp_msb  = exp_q[WIDTH-1];

  // One multiplier bit per cycle: 2*prod + bit*a is below three times the modulus.
  always_comb begin
    sum   = {2'b00, prod, 1'b0} + {3'b000, (mult[WIDTH-1] ? a_op : '0)};
    diff1 = sum - {3'b000, modulus};
    diff2 = sum - {2'b00, modulus, 1'b0};
    if (!diff2[WIDTH+2]) begin
      step_val = diff2[WIDTH-1:0];
    end else if (!diff1[WIDTH+2]) begin
      step_val = diff1[WIDTH-1:0];
    end else begin
      step_val = sum[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= word_t'(1);
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_q <= base;
      exp_q  <= exponent;
    end else if (cmd.shift_exp) begin
      exp_q <= exp_q << 1;
    end

    if (cmd.load) begin
      acc <= one_r;
    end else if (cmd.wb_acc) begin
      acc <= step_val;
    end

    if (cmd.wb_base) begin
      base_r <= step_val;
    end

    if (cmd.start) begin
      prod <= '0;
      case (cmd.op)
        OP_REDUCE: begin
          a_op <= one_r;
          mult <= base_q;
        end
        OP_SQUARE: begin
          a_op <= acc;
          mult <= acc;
        end
        OP_MULT: begin
          a_op <= acc;
          mult <= base_r;
        end
        default: begin
          a_op <= acc;
          mult <= acc;
        end
      endcase
    end else if (cmd.step) begin
      prod <= step_val;
      mult <= mult << 1;
    end

    if (cmd.out_load) begin
      case (cmd.res)
        RES_ACC: begin
          power_mod    <= acc;
          modulus_zero <= 1'b0;
        end
        RES_ONE: begin
          power_mod    <= word_t'(1);
          modulus_zero <= 1'b0;
        end
        RES_ZERO: begin
          power_mod    <= '0;
          modulus_zero <= 1'b1;
        end
        default: begin
          power_mod    <= acc;
          modulus_zero <= 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/mexp_controller.sv
// Controller: sequences the reduction, squarings and multiplications per exponent bit.
module mexp_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mexp_pkg::status_t status,
  output mexp_pkg::cmd_t    cmd
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_NEXT,
    ST_FINISH
  } state_t;

  state_t state, state_next;
  op_t    run_op, run_op_next;
  cnt_t   step_cnt, step_cnt_next;
  cnt_t   bit_cnt, bit_cnt_next;
  res_t   res_sel, res_sel_next;
  logic   out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd           = '0;
    state_next    = state;
    run_op_next   = run_op;
    step_cnt_next = step_cnt;
    bit_cnt_next  = bit_cnt;
    res_sel_next  = res_sel;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.mod_zero) begin
          res_sel_next = RES_ZERO;
          state_next   = ST_FINISH;
        end else if (status.exp_zero) begin
          res_sel_next = RES_ONE;
          state_next   = ST_FINISH;
        end else begin
          cmd.start     = 1'b1;
          cmd.op        = OP_REDUCE;
          run_op_next   = OP_REDUCE;
          step_cnt_next = '0;
          bit_cnt_next  = '0;
          res_sel_next  = RES_ACC;
          state_next    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (step_cnt == cnt_t'(WIDTH-1)) begin
          cmd.wb_base = (run_op == OP_REDUCE);
          cmd.wb_acc  = (run_op != OP_REDUCE);
          state_next  = ST_NEXT;
        end else begin
          step_cnt_next = step_cnt + cnt_t'(1);
        end
      end
      ST_NEXT: begin
        step_cnt_next = '0;
        if (run_op == OP_REDUCE) begin
          cmd.start   = 1'b1;
          cmd.op      = OP_SQUARE;
          run_op_next = OP_SQUARE;
          state_next  = ST_RUN;
        end else if (run_op == OP_SQUARE && status.exp_msb) begin
          cmd.start   = 1'b1;
          cmd.op      = OP_MULT;
          run_op_next = OP_MULT;
          state_next  = ST_RUN;
        end else begin
          cmd.shift_exp = 1'b1;
          if (bit_cnt == cnt_t'(WIDTH-1)) begin
            state_next = ST_FINISH;
          end else begin
            bit_cnt_next = bit_cnt + cnt_t'(1);
            cmd.start    = 1'b1;
            cmd.op       = OP_SQUARE;
            run_op_next  = OP_SQUARE;
            state_next   = ST_RUN;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.res      = res_sel;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      run_op    <= OP_REDUCE;
      step_cnt  <= '0;
      bit_cnt   <= '0;
      res_sel   <= RES_ACC;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      run_op    <= run_op_next;
      step_cnt  <= step_cnt_next;
      bit_cnt   <= bit_cnt_next;
      res_sel   <= res_sel_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/modular_exponentiation_core.sv
// Top level of the modular exponentiation core.
// Computes base to the power exponent modulo the configured modulus by scanning the exponent
// from its most significant bit, squaring at every bit and multiplying by the reduced base
// at every one bit. All products go through one shared modular multiplier that handles one
// multiplier bit per cycle. A zero modulus or a zero exponent goes from the operand check
// straight to the finish state. The modulus is written through cfg_we and cfg_data and
// resets to 1. A result stays in an output register until its transfer, and the next
// operands are taken meanwhile.
`include "assert_macros.svh"

module modular_exponentiation_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  mexp_pkg::word_t cfg_data,
  mexp_in_if.sink         operands,
  mexp_out_if.source      result
);
  import mexp_pkg::*;

  cmd_t    cmd;
  status_t status;

  mexp_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .base         (operands.base),
    .exponent     (operands.exponent),
    .cmd          (cmd),
    .status       (status),
    .power_mod    (result.power_mod),
    .modulus_zero (result.modulus_zero)
  );

  `MEXP_ASSERT(a_busy_after_accept, clk, rst, operands.valid && operands.ready |=> !operands.ready, "Operands taken while busy")
  `MEXP_ASSERT(a_zero_mod_result, clk, rst, result.valid && result.modulus_zero |-> result.power_mod == '0, "Zero modulus result not zero")
  `MEXP_ASSERT_NEVER(a_no_overwrite, clk, rst, cmd.out_load && result.valid && !result.ready, "Pending result overwritten")
  `MEXP_ASSERT_NEVER(a_step_and_start, clk, rst, cmd.step && (cmd.start || cmd.load), "Multiplier stepped while loading")

endmodule

### test/modular_exponentiation_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench that drives operands into the modular exponentiation core and checks each power against its own prediction.
module modular_exponentiation_core_test;
  import mexp_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    word_t power_mod;
    logic  modulus_zero;
  } power_result_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cfg_we = 1'b0;
  word_t cfg_data = '0;

  mexp_in_if  operands_ch ();
  mexp_out_if results_ch ();

  modular_exponentiation_core uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .operands (operands_ch),
    .result   (results_ch)
  );

  word_t         modulus_now = 32'd1;
  power_result_t expected_powers[$];
  int            error_count = 0;
  int            idle_cycles = 0;
  int            burst_left = 0;

  always #2 clk = ~clk;

  function automatic power_result_t predict_power(word_t b, word_t e, word_t m);
    power_result_t r;
    bit [63:0]     running;
    bit [63:0]     base_red;
    bit [63:0]     mm;
    r.modulus_zero = 1'b0;
    r.power_mod = '0;
    if (m == '0) begin
      r.modulus_zero = 1'b1;
      return r;
    end
    if (e == '0) begin
      r.power_mod = word_t'(1);
      return r;
    end
    mm = 64'(m);
    base_red = 64'(b) % mm;
    running = 64'd1 % mm;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      running = (running * running) % mm;
      if (e[i]) begin
        running = (running * base_red) % mm;
      end
    end
    r.power_mod = running[WIDTH-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, word_t want, word_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("mismatch in %s: expected %h, got %h", field, want, got);
    end
  endtask

  task automatic send_operands(word_t b, word_t e);
    if (burst_left == 0) begin
      operands_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
    end
    operands_ch.valid <= 1'b1;
    operands_ch.base <= b;
    operands_ch.exponent <= e;
    do @(posedge clk); while (operands_ch.ready !== 1'b1);
    expected_powers.push_back(predict_power(b, e, modulus_now));
    burst_left--;
  endtask

  task automatic drain_results();
    operands_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_powers.size() != 0);
  endtask

  task automatic write_modulus(word_t m);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_now = m;
  endtask

  task automatic test_reset_modulus();
    send_operands(32'd5, 32'd0);
    send_operands(32'd5, 32'd3);
    send_operands(32'd0, 32'd0);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_zero_modulus();
    write_modulus(32'd0);
    send_operands(32'd0, 32'd0);
    send_operands(32'd7, 32'd5);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_extremes();
    write_modulus(32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_operands(32'd0, 32'd5);
    send_operands(32'd1, 32'hFFFF_FFFF);
    send_operands(32'd2, 32'd31);
    send_operands(32'd2, 32'd32);
    send_operands(32'd12345, 32'd0);
  endtask

  task automatic test_square_multiply();
    write_modulus(32'd1_000_000_007);
    send_operands(32'd3, 32'h5555_5555);
    send_operands(32'd3, 32'hAAAA_AAAA);
    send_operands(32'h8000_0000, 32'd2);
    send_operands(32'hDEAD_BEEF, 32'd1);
    send_operands(32'd2, 32'h8000_0000);
  endtask

  task automatic test_small_moduli();
    write_modulus(32'd2);
    send_operands(32'd3, 32'd7);
    send_operands(32'd4, 32'd1);
    write_modulus(32'h8000_0000);
    send_operands(32'd3, 32'h7FFF_FFFF);
  endtask

  task automatic test_random(int count, word_t m);
    word_t b;
    word_t e;
    write_modulus(m);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: b = '0;
        1: b = word_t'(1);
        2: b = m - word_t'(1);
        3: b = '1;
        default: b = $urandom;
      endcase
      case ($urandom_range(0, 19))
        0, 1: e = '0;
        2: e = '1;
        3, 4: e = word_t'(1) << $urandom_range(0, WIDTH - 1);
        5, 6, 7: e = $urandom_range(1, 40);
        default: e = $urandom;
      endcase
      send_operands(b, e);
    end
  endtask

  initial begin
    operands_ch.valid = 1'b0;
    operands_ch.base = '0;
    operands_ch.exponent = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_modulus();
    test_zero_modulus();
    test_extremes();
    test_square_multiply();
    test_small_moduli();
    test_random(36, $urandom);
    test_random(36, '1);
    test_random(36, $urandom_range(2, 300));
    test_random(36, word_t'(1) << $urandom_range(0, WIDTH - 1));
    test_random(12, '0);
    test_random(36, 32'h8000_0000 | $urandom);
    test_random(36, 32'hFFFF_FFFB);
    test_random(30, $urandom);
    test_random(8, 32'd1);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    error_count += expected_powers.size();
    if (error_count == 0) begin
      $display("[modular_exponentiation_core] OK");
    end else begin
      $display("[modular_exponentiation_core] ERROR");
    end
    $finish;
  end

  initial begin
    int hold;
    bit stalling;
    hold = 0;
    stalling = 1'b1;
    results_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= 1'b1;
        if (stalling && $urandom_range(0, 2) == 0) begin
          hold = $urandom_range(1, 40);
        end
      end
      if ($urandom_range(0, 299) == 0) begin
        stalling = !stalling;
      end
    end
  end

  always @(posedge clk) begin
    power_result_t want;
    if (!rst && results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
      if (expected_powers.size() == 0) begin
        report_mismatch("unexpected transfer", '0, results_ch.power_mod);
      end else begin
        want = expected_powers.pop_front();
        if (results_ch.power_mod !== want.power_mod) begin
          report_mismatch("power_mod", want.power_mod, results_ch.power_mod);
        end
        if (results_ch.modulus_zero !== want.modulus_zero) begin
          report_mismatch("modulus_zero", word_t'(want.modulus_zero),
                          word_t'(results_ch.modulus_zero));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((operands_ch.valid === 1'b1 && operands_ch.ready === 1'b1) ||
        (results_ch.valid === 1'b1 && results_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[modular_exponentiation_core] ERROR");
      $finish;
    end
  end

endmodule

### filelist.f
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_if.sv
rtl/mexp_datapath.sv
rtl/mexp_controller.sv
rtl/modular_exponentiation_core.sv
test/modular_exponentiation_core_test.sv
